// ----- hdl/axrot_pkg.sv -----
package axrot_pkg;

	localparam int FUNC_W            = 2;
	localparam int ANGLE_W           = 19;
	localparam int ELEM_W            = 16;
	localparam int WORK_W            = 34;
	localparam int WORK_FRAC         = 30;
	localparam int FOLD_W            = ANGLE_W + 1;
	localparam int ATAN_COUNT        = 24;
	localparam int DEF_CORDIC_STAGES = 16;
	localparam int DEF_OUT_FRAC_BITS = 14;

	localparam logic signed [FOLD_W-1:0] ANG_PI      = FOLD_W'(205887);
	localparam logic signed [FOLD_W-1:0] ANG_HALF_PI = FOLD_W'(102944);
	localparam logic signed [WORK_W-1:0] CORDIC_GAIN = WORK_W'(652032874);

	typedef enum logic [FUNC_W-1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	typedef struct packed {
		logic signed [WORK_W-1:0] x;
		logic signed [WORK_W-1:0] y;
		logic signed [WORK_W-1:0] z;
		logic                     neg;
		axis_t                    axis;
	} cordic_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] c;
		logic signed [ELEM_W-1:0] s;
		logic                     neg;
		axis_t                    axis;
	} trig_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] m00;
		logic signed [ELEM_W-1:0] m01;
		logic signed [ELEM_W-1:0] m02;
		logic signed [ELEM_W-1:0] m10;
		logic signed [ELEM_W-1:0] m11;
		logic signed [ELEM_W-1:0] m12;
		logic signed [ELEM_W-1:0] m20;
		logic signed [ELEM_W-1:0] m21;
		logic signed [ELEM_W-1:0] m22;
	} mat_t;

	function automatic logic signed [WORK_W-1:0] atan_q30(input int idx);
		logic [30:0] a;
		case (idx)
			0:  a = 31'd843314856;
			1:  a = 31'd497837829;
			2:  a = 31'd263043836;
			3:  a = 31'd133525158;
			4:  a = 31'd67021686;
			5:  a = 31'd33543515;
			6:  a = 31'd16775850;
			7:  a = 31'd8388437;
			8:  a = 31'd4194282;
			9:  a = 31'd2097149;
			10: a = 31'd1048575;
			11: a = 31'd524287;
			12: a = 31'd262143;
			13: a = 31'd131071;
			14: a = 31'd65535;
			15: a = 31'd32767;
			16: a = 31'd16383;
			17: a = 31'd8191;
			18: a = 31'd4095;
			19: a = 31'd2047;
			20: a = 31'd1023;
			21: a = 31'd511;
			22: a = 31'd255;
			23: a = 31'd127;
			default: a = '0;
		endcase
		return $signed({{(WORK_W-31){1'b0}}, a});
	endfunction

endpackage

// ----- hdl/axrot_in_if.sv -----
interface axrot_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [axrot_pkg::FUNC_W-1:0]           func;
	logic signed [axrot_pkg::ANGLE_W-1:0]   angle;

	modport source(output valid, func, angle, input ready);
	modport sink(input valid, func, angle, output ready);
endinterface

// ----- hdl/axrot_out_if.sv -----
interface axrot_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [axrot_pkg::ELEM_W-1:0]  m00;
	logic signed [axrot_pkg::ELEM_W-1:0]  m01;
	logic signed [axrot_pkg::ELEM_W-1:0]  m02;
	logic signed [axrot_pkg::ELEM_W-1:0]  m10;
	logic signed [axrot_pkg::ELEM_W-1:0]  m11;
	logic signed [axrot_pkg::ELEM_W-1:0]  m12;
	logic signed [axrot_pkg::ELEM_W-1:0]  m20;
	logic signed [axrot_pkg::ELEM_W-1:0]  m21;
	logic signed [axrot_pkg::ELEM_W-1:0]  m22;

	modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
	modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

// ----- hdl/axrot_fold.sv -----
module axrot_fold (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 up_valid,
	output logic                                 up_ready,
	input  logic [axrot_pkg::FUNC_W-1:0]         func,
	input  logic signed [axrot_pkg::ANGLE_W-1:0] angle,
	output logic                                 dn_valid,
	input  logic                                 dn_ready,
	output axrot_pkg::cordic_t                   dn_data
);

	logic                                      v_s1;
	axrot_pkg::cordic_t                        d_s1;
	axrot_pkg::cordic_t                        nxt;
	logic signed [axrot_pkg::FOLD_W-1:0]       a_ext;
	logic signed [axrot_pkg::FOLD_W-1:0]       a_fold;
	logic                                      neg;

	// fold into [-pi/2, pi/2]; negate c and s later
	always_comb begin
		a_ext = {angle[axrot_pkg::ANGLE_W-1], angle};
		if (a_ext > axrot_pkg::ANG_HALF_PI) begin
			a_fold = a_ext - axrot_pkg::ANG_PI;
			neg    = 1'b1;
		end else if (a_ext < -axrot_pkg::ANG_HALF_PI) begin
			a_fold = a_ext + axrot_pkg::ANG_PI;
			neg    = 1'b1;
		end else begin
			a_fold = a_ext;
			neg    = 1'b0;
		end
		nxt.x    = axrot_pkg::CORDIC_GAIN;
		nxt.y    = '0;
		nxt.z    = axrot_pkg::WORK_W'(a_fold) <<< 14;
		nxt.neg  = neg;
		nxt.axis = axrot_pkg::axis_t'(func);
	end

	assign up_ready = !v_s1 || dn_ready;
	assign dn_valid = v_s1;
	assign dn_data  = d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (up_ready) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			d_s1 <= nxt;
		end
	end

endmodule

// ----- hdl/axrot_cordic.sv -----
module axrot_cordic #(
	parameter int CORDIC_STAGES = axrot_pkg::DEF_CORDIC_STAGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  axrot_pkg::cordic_t up_data,
	output logic               dn_valid,
	input  logic               dn_ready,
	output axrot_pkg::cordic_t dn_data
);

	localparam int MSB = axrot_pkg::WORK_W - 1;

	logic [CORDIC_STAGES-1:0] stg_v_s;
	axrot_pkg::cordic_t       stg_d_s [CORDIC_STAGES];
	logic [CORDIC_STAGES-1:0] rdy;

	genvar k;
	generate
		for (k = 0; k < CORDIC_STAGES; k++) begin : g_stage
			axrot_pkg::cordic_t       src;
			axrot_pkg::cordic_t       nxt;
			logic                     src_v;
			logic signed [MSB:0]      xs;
			logic signed [MSB:0]      ys;
			logic signed [MSB:0]      at;

			if (k == 0) begin : g_head
				assign src   = up_data;
				assign src_v = up_valid;
			end else begin : g_body
				assign src   = stg_d_s[k-1];
				assign src_v = stg_v_s[k-1];
			end

			if (k == CORDIC_STAGES - 1) begin : g_tail
				assign rdy[k] = !stg_v_s[k] || dn_ready;
			end else begin : g_link
				assign rdy[k] = !stg_v_s[k] || rdy[k+1];
			end

			assign xs = src.x >>> k;
			assign ys = src.y >>> k;
			assign at = axrot_pkg::atan_q30(k);

			always_comb begin
				nxt = src;
				if (!src.z[MSB]) begin
					nxt.x = src.x - ys;
					nxt.y = src.y + xs;
					nxt.z = src.z - at;
				end else begin
					nxt.x = src.x + ys;
					nxt.y = src.y - xs;
					nxt.z = src.z + at;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					stg_v_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					stg_v_s[k] <= src_v;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					stg_d_s[k] <= nxt;
				end
			end
		end
	endgenerate

	assign up_ready = rdy[0];
	assign dn_valid = stg_v_s[CORDIC_STAGES-1];
	assign dn_data  = stg_d_s[CORDIC_STAGES-1];

endmodule

// ----- hdl/axrot_matrix.sv -----
module axrot_matrix #(
	parameter int OUT_FRAC_BITS = axrot_pkg::DEF_OUT_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  axrot_pkg::cordic_t up_data,
	output logic               dn_valid,
	input  logic               dn_ready,
	output axrot_pkg::mat_t    dn_data
);

	localparam int RW = axrot_pkg::WORK_W + 1;
	localparam int EW = axrot_pkg::ELEM_W;
	localparam int SH = axrot_pkg::WORK_FRAC - OUT_FRAC_BITS;
	localparam logic signed [RW-1:0] HALF =
		(SH > 0) ? RW'(64'sd1 <<< ((SH > 0) ? SH - 1 : 0)) : '0;
	localparam logic signed [RW-1:0] ONE_W = RW'(64'sd1 <<< OUT_FRAC_BITS);
	localparam logic signed [EW-1:0] ONE_E = EW'(64'sd1 <<< OUT_FRAC_BITS);

	logic                   v_s1;
	logic                   v_s2;
	logic                   rdy2;
	axrot_pkg::trig_t       d_s1;
	axrot_pkg::mat_t        d_s2;
	axrot_pkg::trig_t       trig;
	axrot_pkg::mat_t        mat;
	logic signed [RW-1:0]   xr;
	logic signed [RW-1:0]   yr;
	logic signed [RW-1:0]   xq;
	logic signed [RW-1:0]   yq;
	logic signed [EW-1:0]   c;
	logic signed [EW-1:0]   s;
	logic signed [EW-1:0]   sn;

	// round half up, then clamp to plus or minus one
	always_comb begin
		xr = ($signed({up_data.x[axrot_pkg::WORK_W-1], up_data.x}) + HALF) >>> SH;
		yr = ($signed({up_data.y[axrot_pkg::WORK_W-1], up_data.y}) + HALF) >>> SH;
		xq = (xr > ONE_W) ? ONE_W : ((xr < -ONE_W) ? -ONE_W : xr);
		yq = (yr > ONE_W) ? ONE_W : ((yr < -ONE_W) ? -ONE_W : yr);
		trig.c    = xq[EW-1:0];
		trig.s    = yq[EW-1:0];
		trig.neg  = up_data.neg;
		trig.axis = up_data.axis;
	end

	always_comb begin
		c   = d_s1.neg ? -d_s1.c : d_s1.c;
		s   = d_s1.neg ? -d_s1.s : d_s1.s;
		sn  = -s;
		mat = '0;
		unique case (d_s1.axis)
			axrot_pkg::AXIS_X: begin
				mat.m00 = ONE_E;
				mat.m11 = c;
				mat.m12 = s;
				mat.m21 = sn;
				mat.m22 = c;
			end
			axrot_pkg::AXIS_Y: begin
				mat.m00 = c;
				mat.m02 = sn;
				mat.m11 = ONE_E;
				mat.m20 = s;
				mat.m22 = c;
			end
			axrot_pkg::AXIS_Z: begin
				mat.m00 = c;
				mat.m01 = s;
				mat.m10 = sn;
				mat.m11 = c;
				mat.m22 = ONE_E;
			end
			axrot_pkg::AXIS_NONE: begin
				mat.m00 = ONE_E;
				mat.m11 = ONE_E;
				mat.m22 = ONE_E;
			end
		endcase
	end

	assign rdy2     = !v_s2 || dn_ready;
	assign up_ready = !v_s1 || rdy2;
	assign dn_valid = v_s2;
	assign dn_data  = d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (up_ready) begin
				v_s1 <= up_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			d_s1 <= trig;
		end
		if (rdy2) begin
			d_s2 <= mat;
		end
	end

endmodule

// ----- hdl/axis_rotation_matrix_top.sv -----
// Direction cosine matrix for a rotation about the x, y or z axis. Each angle_ch
// transfer carries an axis code (0 = x, 1 = y, 2 = z, 3 = identity) and a signed
// Q2.16 angle in radians, which the caller keeps within [-pi, pi]; each matrix_ch
// transfer carries the nine Q1.14 elements. One transfer is taken every cycle
// while matrix_ch does not stall. The path has one quadrant-fold register, one
// register per CORDIC iteration, one round and saturate register and one output
// register. Every stage holds its own valid bit, so a stall on matrix_ch fills
// empty stages first and only then drops angle_ch.ready.
module axis_rotation_matrix_top #(
	parameter int CORDIC_STAGES = axrot_pkg::DEF_CORDIC_STAGES,
	parameter int OUT_FRAC_BITS = axrot_pkg::DEF_OUT_FRAC_BITS
) (
	input logic        clk,
	input logic        arst_n,
	axrot_in_if.sink   angle_ch,
	axrot_out_if.source matrix_ch
);

	logic               fold_v;
	logic               fold_r;
	axrot_pkg::cordic_t fold_d;
	logic               cor_v;
	logic               cor_r;
	axrot_pkg::cordic_t cor_d;
	axrot_pkg::mat_t    mat;

	axrot_fold u_fold (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (angle_ch.valid),
		.up_ready (angle_ch.ready),
		.func     (angle_ch.func),
		.angle    (angle_ch.angle),
		.dn_valid (fold_v),
		.dn_ready (fold_r),
		.dn_data  (fold_d)
	);

	axrot_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (fold_v),
		.up_ready (fold_r),
		.up_data  (fold_d),
		.dn_valid (cor_v),
		.dn_ready (cor_r),
		.dn_data  (cor_d)
	);

	axrot_matrix #(
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cor_v),
		.up_ready (cor_r),
		.up_data  (cor_d),
		.dn_valid (matrix_ch.valid),
		.dn_ready (matrix_ch.ready),
		.dn_data  (mat)
	);

	assign matrix_ch.m00 = mat.m00;
	assign matrix_ch.m01 = mat.m01;
	assign matrix_ch.m02 = mat.m02;
	assign matrix_ch.m10 = mat.m10;
	assign matrix_ch.m11 = mat.m11;
	assign matrix_ch.m12 = mat.m12;
	assign matrix_ch.m20 = mat.m20;
	assign matrix_ch.m21 = mat.m21;
	assign matrix_ch.m22 = mat.m22;

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!matrix_ch.valid |-> angle_ch.ready)
		else $error("pipeline empty at output but input stalled");

	a_skew: assert property (@(posedge clk) disable iff (!arst_n)
		matrix_ch.valid |-> (matrix_ch.m10 == axrot_pkg::ELEM_W'(-matrix_ch.m01)) &&
			(matrix_ch.m20 == axrot_pkg::ELEM_W'(-matrix_ch.m02)) &&
			(matrix_ch.m21 == axrot_pkg::ELEM_W'(-matrix_ch.m12)))
		else $error("off-diagonal elements not antisymmetric");

	a_diag: assert property (@(posedge clk) disable iff (!arst_n)
		matrix_ch.valid |-> (matrix_ch.m00 == matrix_ch.m11) ||
			(matrix_ch.m00 == matrix_ch.m22) || (matrix_ch.m11 == matrix_ch.m22))
		else $error("diagonal has no cosine pair");

endmodule
